/* hdl/wwm_pkg.sv */
// Shared types and constants for the wrapped window mean block.
// Holds the job word passed from the front end through the queue to the back end.
// No dependencies.
package wwm_pkg;

    // Widths that cover the largest supported grid (4096 x 4096).
    localparam int ROW_MAX_W   = 12;
    localparam int COL_MAX_W   = 12;
    localparam int ADDR_MAX_W  = 24;
    localparam int ELEV_W      = 16;
    localparam int COUNT_W     = 16;
    localparam int QUEUE_DEPTH = 2;

    // Request kinds carried by the req_type field.
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    // One classified word: a cell load or a window query broken into row
    // range and up to two column segments per row.
    typedef struct packed {
        t_req                     kind;
        logic [ADDR_MAX_W-1:0]    base;
        logic [ROW_MAX_W-1:0]     row_lo;
        logic [ROW_MAX_W-1:0]     row_hi;
        logic                     rows_en;
        logic [COL_MAX_W-1:0]     s0_lo;
        logic [COL_MAX_W-1:0]     s0_hi;
        logic                     s0_en;
        logic [COL_MAX_W-1:0]     s1_lo;
        logic [COL_MAX_W-1:0]     s1_hi;
        logic                     s1_en;
        logic signed [ELEV_W-1:0] data;
    } t_job;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

endpackage

/* hdl/wwm_front.sv */
// Front end: classifies each input word into a load or a query job.
// Computes grid addresses, the clamped row range and the wrapped column segments.
// Depends on wwm_pkg.
module wwm_front
    import wwm_pkg::*;
#(
    parameter int GRID_ROWS = 128,
    parameter int GRID_COLS = 256
) (
    input  logic              i_valid,
    input  logic              i_full,
    input  logic              i_req_type,
    input  logic [6:0]        i_cell_row,
    input  logic [7:0]        i_cell_col,
    input  logic signed [15:0] i_cell_elevation,
    input  logic [6:0]        i_lat_bottom,
    input  logic [6:0]        i_lat_top,
    input  logic signed [8:0] i_lon_left,
    input  logic [8:0]        i_lon_right,
    output logic              o_push,
    output t_job              o_job
);

    localparam int CW = $clog2(GRID_COLS);
    localparam int EW = ((CW > 9) ? CW : 9) + 2;
    localparam int RX = ROW_MAX_W + 1;
    localparam int CX = COL_MAX_W + 1;

    logic signed [EW-1:0] lft;
    logic signed [EW-1:0] rgt;
    logic signed [EW-1:0] c_last;
    logic signed [EW-1:0] c_num;
    logic signed [EW-1:0] wrap_lo;
    logic signed [EW-1:0] wrap_hi;
    logic signed [EW-1:0] s0_lo;
    logic signed [EW-1:0] s0_hi;
    logic signed [EW-1:0] s1_lo;
    logic signed [EW-1:0] s1_hi;
    logic                 s0_en;
    logic                 s1_en;
    logic [RX-1:0]        bot;
    logic [RX-1:0]        top;
    logic [RX-1:0]        row_last;
    logic [RX-1:0]        row_hi;
    logic                 load_ok;
    logic [6:0]           addr_row;
    logic                 is_query;

    assign lft      = EW'(i_lon_left);
    assign rgt      = EW'(i_lon_right);
    assign c_last   = EW'(GRID_COLS - 1);
    assign c_num    = EW'(GRID_COLS);
    assign wrap_lo  = c_num + lft;
    assign wrap_hi  = rgt - c_num;
    assign is_query = (t_req'(i_req_type) == REQ_QUERY);

    // Column segments of one row, following the wrap rules of the span.
    always_comb begin
        s0_lo = '0;
        s0_hi = '0;
        s1_lo = '0;
        s1_hi = '0;
        s0_en = 1'b0;
        s1_en = 1'b0;
        priority if (lft < 0 && rgt > c_last) begin
            // Both ends run out: the whole row.
            s0_hi = c_last;
            s0_en = 1'b1;
        end else if (lft < 0) begin
            // Start wraps to the end of the row.
            s0_hi = rgt;
            s0_en = 1'b1;
            s1_lo = (wrap_lo < 0) ? '0 : wrap_lo;
            s1_hi = c_last;
            s1_en = 1'b1;
        end else if (rgt > c_last) begin
            // End wraps to the start of the row.
            s0_lo = lft;
            s0_hi = c_last;
            s0_en = (lft <= c_last);
            s1_hi = (wrap_hi > c_last) ? c_last : wrap_hi;
            s1_en = 1'b1;
        end else begin
            s0_lo = lft;
            s0_hi = rgt;
            s0_en = (lft <= rgt);
        end
    end

    // Row range, clamped to the grid.
    assign bot      = RX'(i_lat_bottom);
    assign top      = RX'(i_lat_top);
    assign row_last = RX'(GRID_ROWS - 1);
    assign row_hi   = (top > row_last) ? row_last : top;

    // Loads outside the grid are accepted and dropped.
    assign load_ok = (RX'(i_cell_row) <= row_last) && (CX'(i_cell_col) <= CX'(GRID_COLS - 1));

    // One address multiply serves both the load cell and the first query row.
    assign addr_row = is_query ? i_lat_bottom : i_cell_row;

    always_comb begin
        o_job.kind    = t_req'(i_req_type);
        o_job.base    = ADDR_MAX_W'(addr_row) * ADDR_MAX_W'(GRID_COLS)
                        + ADDR_MAX_W'(i_cell_col & {8{!is_query}});
        o_job.row_lo  = ROW_MAX_W'(i_lat_bottom);
        o_job.row_hi  = ROW_MAX_W'(row_hi);
        o_job.rows_en = (bot <= top) && (bot <= row_last);
        o_job.s0_lo   = COL_MAX_W'(s0_lo);
        o_job.s0_hi   = COL_MAX_W'(s0_hi);
        o_job.s0_en   = s0_en;
        o_job.s1_lo   = COL_MAX_W'(s1_lo);
        o_job.s1_hi   = COL_MAX_W'(s1_hi);
        o_job.s1_en   = s1_en;
        o_job.data    = i_cell_elevation;
    end

    assign o_push = i_valid && !i_full && (is_query || load_ok);

endmodule

/* hdl/wwm_queue.sv */
// Short job queue between the front end and the back end.
// Each side stalls on its own; full and empty come straight from the fill count.
// Depends on wwm_pkg.
module wwm_queue
    import wwm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_vld,
    output logic o_full
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic [NW-1:0] n_count;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Fill count follows push and pop.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_job  = r_mem[r_rd_ptr];
    assign o_vld  = (r_count != '0);
    assign o_full = (r_count == NW'(QUEUE_DEPTH));

    // A word is never written into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != NW'(QUEUE_DEPTH))
        else $error("queue written while full");

    // A word is never taken from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue read while empty");

    // A push alone raises the fill count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + NW'(1))
        else $error("fill count did not follow a push");

endmodule

/* hdl/wwm_back.sv */
// Back end: owns the elevation grid, writes loads, walks query windows cell by
// cell, divides the sum by the count one quotient bit per cycle and holds the result.
// Depends on wwm_pkg.
module wwm_back
    import wwm_pkg::*;
#(
    parameter int GRID_ROWS = 128,
    parameter int GRID_COLS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_vld,
    input  t_job               i_job,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [15:0] o_mean_elevation,
    output logic [15:0]        o_cell_count,
    output logic               o_empty_window
);

    localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW    = $clog2(GRID_COLS);
    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = RW + CW + 2;
    localparam int SUM_W = CNT_W + ELEV_W;
    localparam int STW   = $clog2(SUM_W);
    localparam int XW    = CNT_W + COUNT_W;

    // Grid memory, undefined until loaded.
    logic signed [ELEV_W-1:0] r_grid [DEPTH];
    logic signed [ELEV_W-1:0] r_rd_data;

    t_state                   r_state, n_state;
    logic [RW-1:0]            r_row, n_row;
    logic [RW-1:0]            r_row_hi, n_row_hi;
    logic [CW-1:0]            r_col, n_col;
    logic                     r_seg, n_seg;
    logic [AW-1:0]            r_base, n_base;
    logic [CW-1:0]            r_s0_lo, n_s0_lo;
    logic [CW-1:0]            r_s0_hi, n_s0_hi;
    logic [CW-1:0]            r_s1_lo, n_s1_lo;
    logic [CW-1:0]            r_s1_hi, n_s1_hi;
    logic                     r_s0_en, n_s0_en;
    logic                     r_s1_en, n_s1_en;
    logic                     r_rd_vld, n_rd_vld;
    logic signed [SUM_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [SUM_W-1:0]         r_quo, n_quo;
    logic [CNT_W-1:0]         r_rem, n_rem;
    logic                     r_neg, n_neg;
    logic [STW-1:0]           r_step, n_step;
    logic                     r_out_vld, n_out_vld;
    logic signed [15:0]       r_mean, n_mean;
    logic [15:0]              r_count, n_count;
    logic                     r_empty, n_empty;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic [CW-1:0]            seg_hi;
    logic                     out_free;
    logic [CNT_W:0]           rem_sh;
    logic [CNT_W:0]           rem_sub;
    logic                     div_ge;
    logic signed [SUM_W-1:0]  acc_neg;
    logic [SUM_W-1:0]         quo_neg;
    logic [XW-1:0]            cnt_x;
    logic [15:0]              cnt_sat;

    assign wr_addr = i_job.base[AW-1:0];
    assign rd_addr = r_base + AW'(r_col);
    assign seg_hi  = r_seg ? r_s1_hi : r_s0_hi;

    // One write port for loads, one registered read port for the walk.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_grid[wr_addr] <= i_job.data;
        end
        r_rd_data <= r_grid[rd_addr];
    end

    // Restoring divider step on the magnitude of the sum.
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_cnt});
    assign rem_sub = rem_sh - {1'b0, r_cnt};
    assign acc_neg = -r_acc;
    assign quo_neg = -r_quo;

    // Reported count saturates at the field's maximum.
    assign cnt_x   = XW'(r_cnt);
    assign cnt_sat = (cnt_x > XW'({COUNT_W{1'b1}})) ? {COUNT_W{1'b1}} : cnt_x[COUNT_W-1:0];

    assign out_free = !r_out_vld || !i_stall;

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_row_hi  = r_row_hi;
        n_col     = r_col;
        n_seg     = r_seg;
        n_base    = r_base;
        n_s0_lo   = r_s0_lo;
        n_s0_hi   = r_s0_hi;
        n_s1_lo   = r_s1_lo;
        n_s1_hi   = r_s1_hi;
        n_s0_en   = r_s0_en;
        n_s1_en   = r_s1_en;
        n_rd_vld  = 1'b0;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_neg     = r_neg;
        n_step    = r_step;
        n_out_vld = r_out_vld && i_stall;
        n_mean    = r_mean;
        n_count   = r_count;
        n_empty   = r_empty;
        o_pop     = 1'b0;
        wr_en     = 1'b0;

        // Read data lands in the cycle after its address.
        if (r_rd_vld) begin
            n_acc = r_acc + SUM_W'(r_rd_data);
            n_cnt = r_cnt + CNT_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_job_vld) begin
                    o_pop = 1'b1;
                    if (i_job.kind == REQ_LOAD) begin
                        wr_en = 1'b1;
                    end else begin
                        n_acc    = '0;
                        n_cnt    = '0;
                        n_row    = i_job.row_lo[RW-1:0];
                        n_row_hi = i_job.row_hi[RW-1:0];
                        n_base   = i_job.base[AW-1:0];
                        n_s0_lo  = i_job.s0_lo[CW-1:0];
                        n_s0_hi  = i_job.s0_hi[CW-1:0];
                        n_s1_lo  = i_job.s1_lo[CW-1:0];
                        n_s1_hi  = i_job.s1_hi[CW-1:0];
                        n_s0_en  = i_job.s0_en;
                        n_s1_en  = i_job.s1_en;
                        n_seg    = !i_job.s0_en;
                        n_col    = i_job.s0_en ? i_job.s0_lo[CW-1:0] : i_job.s1_lo[CW-1:0];
                        if (i_job.rows_en && (i_job.s0_en || i_job.s1_en)) begin
                            n_state = S_WALK;
                        end else begin
                            n_state = S_PREP;
                        end
                    end
                end
            end
            S_WALK: begin
                // Issue one cell read per cycle.
                n_rd_vld = 1'b1;
                if (r_col == seg_hi) begin
                    if (!r_seg && r_s1_en) begin
                        n_seg = 1'b1;
                        n_col = r_s1_lo;
                    end else if (r_row == r_row_hi) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_row  = r_row + RW'(1);
                        n_base = r_base + AW'(GRID_COLS);
                        n_seg  = !r_s0_en;
                        n_col  = r_s0_en ? r_s0_lo : r_s1_lo;
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                // Set up the divider on the magnitude of the sum.
                n_neg  = r_acc[SUM_W-1];
                n_quo  = r_acc[SUM_W-1] ? acc_neg : r_acc;
                n_rem  = '0;
                n_step = STW'(SUM_W - 1);
                if (r_cnt == '0) begin
                    n_quo   = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], div_ge};
                if (r_step == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_step = r_step - STW'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_mean    = r_neg ? quo_neg[15:0] : r_quo[15:0];
                    n_count   = cnt_sat;
                    n_empty   = (r_cnt == '0);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_row_hi <= n_row_hi;
        r_col    <= n_col;
        r_seg    <= n_seg;
        r_base   <= n_base;
        r_s0_lo  <= n_s0_lo;
        r_s0_hi  <= n_s0_hi;
        r_s1_lo  <= n_s1_lo;
        r_s1_hi  <= n_s1_hi;
        r_s0_en  <= n_s0_en;
        r_s1_en  <= n_s1_en;
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_neg    <= n_neg;
        r_step   <= n_step;
        r_mean   <= n_mean;
        r_count  <= n_count;
        r_empty  <= n_empty;
    end

    assign o_valid          = r_out_vld;
    assign o_mean_elevation = r_mean;
    assign o_cell_count     = r_count;
    assign o_empty_window   = r_empty;

    // Returning read data only follows a walk cycle.
    a_read_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state) == S_WALK)
        else $error("cell read returned outside a walk");

    // Every returning cell is counted exactly once.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |=> r_cnt == $past(r_cnt) + CNT_W'(1))
        else $error("cell count did not advance");

    // The partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_cnt)
        else $error("divider remainder out of range");

    // The empty flag agrees with the reported count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_empty == (r_count == '0))
        else $error("empty flag disagrees with count");

endmodule

/* hdl/wrapped_window_mean.sv */
// A query walks the N cells it covers (one grid read per cycle), then divides the sum
// in SUM_W steps (clog2 of rows + clog2 of columns + 18, 33 at 128 x 256).
// Queries are worked one at a time; the input keeps accepting into a two-word queue.
// Reset clears the queue, sequencer and output; grid contents are not cleared.
module wrapped_window_mean
    import wwm_pkg::*;
#(
    parameter int GRID_ROWS = 128,
    parameter int GRID_COLS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic [6:0]         i_cell_row,
    input  logic [7:0]         i_cell_col,
    input  logic signed [15:0] i_cell_elevation,
    input  logic [6:0]         i_lat_bottom,
    input  logic [6:0]         i_lat_top,
    input  logic signed [8:0]  i_lon_left,
    input  logic [8:0]         i_lon_right,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_mean_elevation,
    output logic [15:0]        o_cell_count,
    output logic               o_empty_window
);

    t_job front_job;
    t_job queue_job;
    logic push;
    logic pop;
    logic queue_vld;
    logic queue_full;

    // Classify each word.
    wwm_front #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_front (
        .i_valid          (i_valid),
        .i_full           (queue_full),
        .i_req_type       (i_req_type),
        .i_cell_row       (i_cell_row),
        .i_cell_col       (i_cell_col),
        .i_cell_elevation (i_cell_elevation),
        .i_lat_bottom     (i_lat_bottom),
        .i_lat_top        (i_lat_top),
        .i_lon_left       (i_lon_left),
        .i_lon_right      (i_lon_right),
        .o_push           (push),
        .o_job            (front_job)
    );

    // Decouple the two sides.
    wwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_vld   (queue_vld),
        .o_full  (queue_full)
    );

    // Execute loads and queries.
    wwm_back #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_vld        (queue_vld),
        .i_job            (queue_job),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_mean_elevation (o_mean_elevation),
        .o_cell_count     (o_cell_count),
        .o_empty_window   (o_empty_window)
    );

    assign o_stall = queue_full;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for wrapped_window_mean: loads one full row and the edge columns
// of a few more rows, then runs directed and random loads and queries against a predictor.
// Depends on wwm_pkg and wrapped_window_mean; both handshake sides idle at random.
module testbench
    import wwm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = 128;
    localparam int COLS = 256;
    localparam int EDGE = 8;
    localparam int EDGE_ROWS = 4;
    localparam int RANDOM_ITEMS = 240;
    localparam int LONG_HOLD = 400;
    localparam int END_QUIET = 200;

    // Receiver stall patterns.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_SOLID
    } t_stall_mode;

    // One expected window result.
    typedef struct {
        logic signed [15:0] mean;
        logic [15:0]        count;
        logic               empty;
    } t_window_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_req_type = REQ_LOAD;
    logic [6:0]         i_cell_row = '0;
    logic [7:0]         i_cell_col = '0;
    logic signed [15:0] i_cell_elevation = '0;
    logic [6:0]         i_lat_bottom = '0;
    logic [6:0]         i_lat_top = '0;
    logic signed [8:0]  i_lon_left = '0;
    logic [8:0]         i_lon_right = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_mean_elevation;
    logic [15:0]        o_cell_count;
    logic               o_empty_window;

    // Predictor state: a copy of the grid, which cells were loaded, and pending results.
    logic signed [15:0] grid_copy [0:ROWS*COLS-1];
    bit                 written [0:ROWS*COLS-1];
    t_window_result     pending_means [$];
    int                 error_count = 0;

    // Sender burst control.
    int  burst_left = 0;
    int  gap_max = 8;
    bit  offering = 1'b0;

    // Receiver long hold-off request, toggled by the test sequence.
    bit  hold_toggle = 1'b0;

    wrapped_window_mean #(
        .GRID_ROWS(ROWS),
        .GRID_COLS(COLS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_cell_row       (i_cell_row),
        .i_cell_col       (i_cell_col),
        .i_cell_elevation (i_cell_elevation),
        .i_lat_bottom     (i_lat_bottom),
        .i_lat_top        (i_lat_top),
        .i_lon_left       (i_lon_left),
        .i_lon_right      (i_lon_right),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mean_elevation (o_mean_elevation),
        .o_cell_count     (o_cell_count),
        .o_empty_window   (o_empty_window)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Add the clamped column segment c0..c1 of one row to the running totals.
    function automatic void add_columns(input int row, input int c0, input int c1,
                                        inout longint total, inout int cells,
                                        inout bit clean);
        int lo;
        int hi;
        lo = (c0 < 0) ? 0 : c0;
        hi = (c1 > COLS - 1) ? COLS - 1 : c1;
        for (int c = lo; c <= hi; c++) begin
            if (!written[row*COLS + c]) clean = 1'b0;
            total += longint'(grid_copy[row*COLS + c]);
            cells++;
        end
    endfunction

    // Walk every cell of a window, with wrap around the column axis.
    function automatic void walk_window(input logic [6:0] bot, input logic [6:0] top,
                                        input logic signed [8:0] left,
                                        input logic [8:0] right, inout longint total,
                                        inout int cells, inout bit clean);
        int lo;
        int hi;
        lo = int'(left);
        hi = int'(right);
        for (int r = int'(bot); r <= int'(top); r++) begin
            if (r >= ROWS) break;
            if (lo < 0 && hi > COLS - 1) begin
                add_columns(r, 0, COLS - 1, total, cells, clean);
            end else if (lo < 0) begin
                add_columns(r, 0, hi, total, cells, clean);
                add_columns(r, COLS + lo, COLS - 1, total, cells, clean);
            end else if (hi > COLS - 1) begin
                add_columns(r, lo, COLS - 1, total, cells, clean);
                add_columns(r, 0, hi - COLS, total, cells, clean);
            end else begin
                add_columns(r, lo, hi, total, cells, clean);
            end
        end
    endfunction

    // True when a window touches only loaded cells.
    function automatic bit window_clean(input logic [6:0] bot, input logic [6:0] top,
                                        input logic signed [8:0] left,
                                        input logic [8:0] right);
        longint total;
        int     cells;
        bit     clean;
        total = 0;
        cells = 0;
        clean = 1'b1;
        walk_window(bot, top, left, right, total, cells, clean);
        return clean;
    endfunction

    // Mean, count and empty flag of a window.
    function automatic t_window_result window_mean(input logic [6:0] bot,
                                                   input logic [6:0] top,
                                                   input logic signed [8:0] left,
                                                   input logic [8:0] right);
        t_window_result res;
        longint         total;
        int             cells;
        bit             clean;
        longint         quotient;
        total = 0;
        cells = 0;
        clean = 1'b1;
        walk_window(bot, top, left, right, total, cells, clean);
        if (cells == 0) begin
            res.mean = '0;
            res.count = '0;
            res.empty = 1'b1;
        end else begin
            // Signed division truncates toward zero.
            quotient = total / longint'(cells);
            res.mean = quotient[15:0];
            res.count = (cells > 65535) ? 16'hFFFF : 16'(cells);
            res.empty = 1'b0;
        end
        return res;
    endfunction

    // Offer one word, hold it until accepted, predict, then maybe leave a gap.
    task automatic send_word(input t_req kind, input logic [6:0] row, input logic [7:0] col,
                             input logic signed [15:0] elev, input logic [6:0] bot,
                             input logic [6:0] top, input logic signed [8:0] left,
                             input logic [8:0] right);
        int gap;
        i_valid <= 1'b1;
        offering = 1'b1;
        i_req_type <= kind;
        i_cell_row <= row;
        i_cell_col <= col;
        i_cell_elevation <= elev;
        i_lat_bottom <= bot;
        i_lat_top <= top;
        i_lon_left <= left;
        i_lon_right <= right;
        do @(posedge i_clk); while (o_stall);
        if (kind == REQ_LOAD) begin
            grid_copy[int'(row)*COLS + int'(col)] = elev;
            written[int'(row)*COLS + int'(col)] = 1'b1;
        end else begin
            if (!window_clean(bot, top, left, right)) begin
                $error("query window reads a cell that was never loaded");
                error_count++;
            end
            pending_means.push_back(window_mean(bot, top, left, right));
        end
        // Bursts of random length, separated by random gaps.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 31);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                i_valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering and wait until every pending result has come back.
    task automatic wait_drain();
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge i_clk); while (pending_means.size() != 0);
    endtask

    // Random cell load, mostly inside the loaded area; the query fields carry noise.
    task automatic send_random_load();
        logic signed [15:0] elev;
        int                 row;
        int                 col;
        elev = 16'($urandom);
        if ($urandom_range(0, 9) == 0) elev = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if ($urandom_range(0, 9) < 7) begin
            row = $urandom_range(0, EDGE_ROWS);
            col = $urandom_range(0, 2*EDGE - 1);
            if (col >= EDGE) col = COLS - 2*EDGE + col;
            if (row == 0) col = $urandom_range(0, COLS-1);
        end else begin
            row = $urandom_range(0, ROWS-1);
            col = $urandom_range(0, COLS-1);
        end
        send_word(REQ_LOAD, 7'(row), 8'(col), elev,
                  7'($urandom), 7'($urandom), 9'($urandom), 9'($urandom));
    endtask

    // Random window query over loaded cells, with all kinds of column spans.
    task automatic send_random_query();
        int bot;
        int top;
        int pick;
        int left;
        int right;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            bot = 0;
            top = 0;
        end else if (pick < 90) begin
            bot = $urandom_range(0, EDGE_ROWS);
            top = bot + int'($urandom_range(0, 2));
            if (top > EDGE_ROWS) top = EDGE_ROWS;
        end else begin
            bot = $urandom_range(1, ROWS-1);
            top = bot - int'($urandom_range(1, 4));
            if (top < 0) top = 0;
        end
        if (bot == 0 && top == 0) begin
            // The first row is fully loaded: any span.
            pick = $urandom_range(0, 99);
            if (pick < 25) left = 0 - int'($urandom_range(1, 255));
            else if (pick < 85) left = $urandom_range(0, COLS-1);
            else left = int'($urandom_range(0, 510)) - 255;
            if ($urandom_range(0, 99) < 60) right = $urandom_range(0, COLS-1);
            else right = $urandom_range(COLS, 510);
        end else begin
            // Edge rows: spans stay within the loaded columns at both ends.
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
                left = 0 - int'($urandom_range(1, EDGE));
                right = $urandom_range(0, EDGE-1);
            end else if (pick == 1) begin
                left = $urandom_range(COLS-EDGE, COLS-1);
                right = $urandom_range(COLS, COLS+EDGE-1);
            end else if (pick == 2) begin
                left = $urandom_range(0, EDGE-1);
                right = $urandom_range(0, EDGE-1);
            end else begin
                left = $urandom_range(COLS-EDGE, COLS-1);
                right = $urandom_range(COLS-EDGE, COLS-1);
            end
        end
        if (!window_clean(7'(bot), 7'(top), 9'(left), 9'(right))) begin
            bot = 0;
            top = 0;
        end
        send_word(REQ_QUERY, 7'($urandom), 8'($urandom), 16'($urandom),
                  7'(bot), 7'(top), 9'(left), 9'(right));
    endtask

    // Load the first row fully and the edge columns of the next few rows.
    task automatic test_grid_preload();
        gap_max = 2;
        for (int c = 0; c < COLS; c++)
            send_word(REQ_LOAD, 7'd0, 8'(c), 16'($urandom),
                      7'($urandom), 7'($urandom), 9'($urandom), 9'($urandom));
        for (int r = 1; r <= EDGE_ROWS; r++) begin
            for (int c = 0; c < EDGE; c++) begin
                send_word(REQ_LOAD, 7'(r), 8'(c), 16'($urandom),
                          7'($urandom), 7'($urandom), 9'($urandom), 9'($urandom));
                send_word(REQ_LOAD, 7'(r), 8'(COLS - 1 - c), 16'($urandom),
                          7'($urandom), 7'($urandom), 9'($urandom), 9'($urandom));
            end
        end
        gap_max = 8;
    endtask

    // A query right behind a load of the same cell must see the new value.
    task automatic test_load_then_query();
        send_word(REQ_LOAD, 7'd1, 8'd3, -16'sd777, 7'd3, 7'd90, -9'sd5, 9'd300);
        send_word(REQ_QUERY, 7'd99, 8'd1, 16'sd5, 7'd1, 7'd1, 9'sd3, 9'd3);
    endtask

    // Largest and smallest elevations, and a mean of minus one half.
    task automatic test_extreme_values();
        send_word(REQ_LOAD, 7'd2, 8'd0, 16'sh7FFF, '0, '0, '0, '0);
        send_word(REQ_LOAD, 7'd2, 8'd1, 16'sh7FFF, '1, '1, '1, '1);
        send_word(REQ_QUERY, '0, '0, '0, 7'd2, 7'd2, 9'sd0, 9'd1);
        send_word(REQ_LOAD, 7'd2, 8'd0, 16'sh8000, '0, '0, '0, '0);
        send_word(REQ_LOAD, 7'd2, 8'd1, 16'sh8000, '0, '0, '0, '0);
        send_word(REQ_QUERY, '1, '1, '1, 7'd2, 7'd2, 9'sd0, 9'd1);
        send_word(REQ_LOAD, 7'd2, 8'd0, 16'sh7FFF, '0, '0, '0, '0);
        send_word(REQ_QUERY, '0, '0, '0, 7'd2, 7'd2, 9'sd0, 9'd1);
    endtask

    // A negative mean truncates toward zero, not downward.
    task automatic test_truncation();
        send_word(REQ_LOAD, 7'd3, 8'd0, -16'sd3, '0, '0, '0, '0);
        send_word(REQ_LOAD, 7'd3, 8'd1, -16'sd2, '0, '0, '0, '0);
        send_word(REQ_QUERY, '0, '0, '0, 7'd3, 7'd3, 9'sd0, 9'd1);
    endtask

    // Plain, reversed and wrapped column spans, including overlapping wraps.
    task automatic test_column_wraps();
        send_word(REQ_QUERY, '0, '0, '0, 7'd0, 7'd0, 9'sd30, 9'd40);
        send_word(REQ_QUERY, '0, '0, '0, 7'd0, 7'd0, 9'sd40, 9'd30);
        send_word(REQ_QUERY, '0, '0, '0, 7'd1, 7'd2, -9'sd5, 9'd5);
        send_word(REQ_QUERY, '0, '0, '0, 7'd3, 7'd4, 9'sd250, 9'd260);
        send_word(REQ_QUERY, '0, '0, '0, 7'd0, 7'd4, -9'sd3, 9'd2);
        send_word(REQ_QUERY, '0, '0, '0, 7'd0, 7'd0, -9'sd200, 9'd100);
        send_word(REQ_QUERY, '0, '0, '0, 7'd0, 7'd0, 9'sd10, 9'd400);
        send_word(REQ_QUERY, '0, '0, '0, 7'd0, 7'd0, -9'sd255, 9'd0);
        send_word(REQ_QUERY, '0, '0, '0, 7'd0, 7'd0, 9'sd255, 9'd510);
    endtask

    // A bottom row above the top row covers nothing.
    task automatic test_empty_rows();
        send_word(REQ_QUERY, '1, '1, '1, 7'd50, 7'd49, -9'sd5, 9'd300);
        send_word(REQ_QUERY, '0, '0, '0, 7'd127, 7'd0, 9'sd0, 9'd255);
    endtask

    // A whole row, once plain and once with the widest overlapping wrap.
    task automatic test_full_rows();
        send_word(REQ_QUERY, '0, '0, '0, 7'd0, 7'd0, -9'sd1, 9'd256);
        send_word(REQ_QUERY, '0, '0, '0, 7'd0, 7'd0, -9'sd255, 9'd255);
        wait_drain();
    endtask

    // The receiver holds off for a long stretch while short queries keep coming.
    task automatic test_output_hold_off();
        int col;
        wait_drain();
        gap_max = 0;
        hold_toggle <= ~hold_toggle;
        for (int n = 0; n < 24; n++) begin
            col = $urandom_range(0, COLS-16);
            if (n % 3 == 2) send_random_load();
            else send_word(REQ_QUERY, 7'($urandom), 8'($urandom), 16'($urandom),
                           7'd0, 7'd0, 9'(col), 9'(col + int'($urandom_range(0, 15))));
        end
        wait_drain();
        gap_max = 8;
    endtask

    // Mixed random loads and queries, with changing gap lengths and drain pauses.
    task automatic test_random_traffic();
        int pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                pick = $urandom_range(0, 2);
                gap_max = (pick == 0) ? 0 : ((pick == 1) ? 4 : 16);
                if (n != 0) wait_drain();
            end
            if ($urandom_range(0, 99) < 55) send_random_query();
            else send_random_load();
        end
    endtask

    // Receiver stall: random patterns, overridden by a long hold-off on request.
    always @(posedge i_clk) begin
        static bit          hold_seen = 1'b0;
        static int          hold_left = 0;
        static int          stall_left = 0;
        static t_stall_mode stall_mode = STALL_NONE;
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(1, 48);
            end
            stall_left--;
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:     i_stall <= 1'b1;
            endcase
        end
    end

    // Compare each accepted result word with the oldest pending expectation.
    always @(posedge i_clk) begin
        t_window_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_means.size() == 0) begin
                $error("result with no query pending: mean %0d count %0d empty %0b",
                       o_mean_elevation, o_cell_count, o_empty_window);
                error_count++;
            end else begin
                want = pending_means.pop_front();
                if (o_mean_elevation !== want.mean) begin
                    $error("mean_elevation: expected %0d, got %0d",
                           want.mean, o_mean_elevation);
                    error_count++;
                end
                if (o_cell_count !== want.count) begin
                    $error("cell_count: expected %0d, got %0d", want.count, o_cell_count);
                    error_count++;
                end
                if (o_empty_window !== want.empty) begin
                    $error("empty_window: expected %0b, got %0b",
                           want.empty, o_empty_window);
                    error_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_grid_preload();
        test_load_then_query();
        test_extreme_values();
        test_truncation();
        test_column_wraps();
        test_empty_rows();
        test_full_rows();
        test_output_hold_off();
        test_random_traffic();
        wait_drain();
        repeat (END_QUIET) @(posedge i_clk);
        if (error_count == 0 && pending_means.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
